@@ rtl/dtt_pkg.sv @@
// ============================================================================
// dtt_pkg - shared types for the delayed action timer table
// Word layouts, result codes, controller states and fixed limits.
// ============================================================================
package dtt_pkg;

    localparam int unsigned TAG_W   = 16;
    localparam int unsigned DELAY_W = 16;
    localparam int unsigned SEC_W   = 11;
    localparam int unsigned STAMP_W = 16;
    localparam int unsigned PPS_W   = 8;

    localparam logic [DELAY_W-1:0] DELAY_MIN = 16'd5;
    localparam logic [DELAY_W-1:0] DELAY_MAX = 16'd1800;
    localparam logic [PPS_W-1:0]   PPS_RESET = 8'd4;

    // Result codes
    typedef enum logic [2:0] {
        EV_ACCEPTED      = 3'd0,
        EV_NOT_PERMITTED = 3'd1,
        EV_NO_DELAY      = 3'd2,
        EV_OUT_OF_RANGE  = 3'd3,
        EV_NO_COMMAND    = 3'd4,
        EV_TABLE_FULL    = 3'd5,
        EV_FIRED         = 3'd6
    } event_kind_t;

    // Input word
    typedef struct packed {
        logic               mode;
        logic               requester_permitted;
        logic               delay_present;
        logic [DELAY_W-1:0] delay_seconds;
        logic               command_present;
        logic [TAG_W-1:0]   command_tag;
    } in_t;

    // Result word
    typedef struct packed {
        event_kind_t      event_kind;
        logic [TAG_W-1:0] tag;
        logic             last;
    } out_t;

    // One table entry as held in the memory
    typedef struct packed {
        logic [SEC_W-1:0]   seconds;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] age;
    } entry_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STATUS,
        ST_WALK,
        ST_SCAN,
        ST_FIRE
    } state_t;

endpackage

@@ rtl/dtt_ram.sv @@
// ============================================================================
// dtt_ram - table entry memory
// One write port and one read port, read data registered.
// ============================================================================
module dtt_ram #(
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned WIDTH  = 43,
    parameter int unsigned ADDR_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write the entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/dtt_prescaler.sv @@
// ============================================================================
// dtt_prescaler - tick to one-second step prescaler
// Holds the reload register and the pulse counter; flags a second step.
// ============================================================================
module dtt_prescaler (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      tick,
    input  logic                      wr_en,
    input  logic [dtt_pkg::PPS_W-1:0] wr_data,
    output logic                      step
);

    logic [dtt_pkg::PPS_W-1:0] pps_reg;
    logic [dtt_pkg::PPS_W-1:0] count_reg;
    logic [dtt_pkg::PPS_W-1:0] count_next;

    // Fire when the count has run down; a zero reload behaves as one
    assign step = tick && (count_reg <= dtt_pkg::PPS_W'(1));

    always_comb
    begin
        count_next = count_reg;
        if (step)
        begin
            count_next = pps_reg;
        end
        else if (tick)
        begin
            count_next = count_reg - dtt_pkg::PPS_W'(1);
        end
    end

    // Hold reload value and advance the counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pps_reg   <= dtt_pkg::PPS_RESET;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                pps_reg <= wr_data;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/dtt_ctrl.sv @@
// ============================================================================
// dtt_ctrl - timer table controller
// Inserts entries, walks the memory on each second step and picks fired
// entries newest first by repeated scans.
// ============================================================================
module dtt_ctrl #(
    parameter int unsigned DEPTH   = 16,
    parameter int unsigned IDX_W   = 4,
    parameter int unsigned ENTRY_W = 43
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  dtt_pkg::in_t       item,
    output logic               item_stall,
    input  logic               step,
    output logic               wr_en,
    output logic [IDX_W-1:0]   wr_addr,
    output logic [ENTRY_W-1:0] wr_data,
    output logic               rd_en,
    output logic [IDX_W-1:0]   rd_addr,
    input  logic [ENTRY_W-1:0] rd_data,
    output logic               res_valid,
    output dtt_pkg::out_t      res,
    input  logic               res_taken
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    dtt_pkg::state_t state_reg;
    dtt_pkg::state_t state_next;

    logic [DEPTH-1:0]            valid_reg;
    logic [DEPTH-1:0]            fired_reg;
    logic [dtt_pkg::STAMP_W-1:0] stamp_reg;
    logic [CNT_W-1:0]            ptr_reg;
    logic                        pv_reg;
    logic [IDX_W-1:0]            pidx_reg;
    logic                        best_found_reg;
    logic [dtt_pkg::STAMP_W-1:0] best_d_reg;
    logic [IDX_W-1:0]            best_idx_reg;
    logic [dtt_pkg::TAG_W-1:0]   best_tag_reg;
    dtt_pkg::out_t               res_reg;

    logic                        accept;
    logic                        issuing;
    logic                        pass_done;
    logic                        free_found;
    logic [IDX_W-1:0]            free_idx;
    dtt_pkg::event_kind_t        kind;
    dtt_pkg::entry_t             rd_entry;
    dtt_pkg::entry_t             new_entry;
    dtt_pkg::entry_t             walk_entry;
    logic [dtt_pkg::STAMP_W-1:0] cand_d;
    logic [DEPTH-1:0]            fired_left;

    assign accept    = item_valid && (state_reg == dtt_pkg::ST_IDLE);
    assign issuing   = ((state_reg == dtt_pkg::ST_WALK) || (state_reg == dtt_pkg::ST_SCAN))
                       && (ptr_reg != CNT_W'(DEPTH));
    assign pass_done = (ptr_reg == CNT_W'(DEPTH)) && !pv_reg;
    assign rd_entry  = dtt_pkg::entry_t'(rd_data);
    assign cand_d    = stamp_reg - rd_entry.age;

    // Find the lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Check a schedule request in order
    always_comb
    begin
        if (!item.requester_permitted)
        begin
            kind = dtt_pkg::EV_NOT_PERMITTED;
        end
        else if (!item.delay_present)
        begin
            kind = dtt_pkg::EV_NO_DELAY;
        end
        else if ((item.delay_seconds < dtt_pkg::DELAY_MIN)
                 || (item.delay_seconds > dtt_pkg::DELAY_MAX))
        begin
            kind = dtt_pkg::EV_OUT_OF_RANGE;
        end
        else if (!item.command_present)
        begin
            kind = dtt_pkg::EV_NO_COMMAND;
        end
        else if (!free_found)
        begin
            kind = dtt_pkg::EV_TABLE_FULL;
        end
        else
        begin
            kind = dtt_pkg::EV_ACCEPTED;
        end
    end

    // Build the new entry and the counted-down entry
    always_comb
    begin
        new_entry.seconds = item.delay_seconds[dtt_pkg::SEC_W-1:0];
        new_entry.tag     = item.command_tag;
        new_entry.age     = stamp_reg;
        walk_entry        = rd_entry;
        if (rd_entry.seconds <= dtt_pkg::SEC_W'(1))
        begin
            walk_entry.seconds = '0;
        end
        else
        begin
            walk_entry.seconds = rd_entry.seconds - dtt_pkg::SEC_W'(1);
        end
    end

    // Work out what is left to fire after the chosen entry
    always_comb
    begin
        fired_left               = fired_reg;
        fired_left[best_idx_reg] = 1'b0;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dtt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.mode)
                    begin
                        state_next = dtt_pkg::ST_STATUS;
                    end
                    else if (step)
                    begin
                        state_next = dtt_pkg::ST_WALK;
                    end
                end
            end
            dtt_pkg::ST_STATUS:
            begin
                if (res_taken)
                begin
                    state_next = dtt_pkg::ST_IDLE;
                end
            end
            dtt_pkg::ST_WALK:
            begin
                if (pass_done)
                begin
                    state_next = (fired_reg != '0) ? dtt_pkg::ST_SCAN : dtt_pkg::ST_IDLE;
                end
            end
            dtt_pkg::ST_SCAN:
            begin
                if (pass_done)
                begin
                    state_next = dtt_pkg::ST_FIRE;
                end
            end
            dtt_pkg::ST_FIRE:
            begin
                if (res_taken)
                begin
                    state_next = (fired_reg != '0) ? dtt_pkg::ST_SCAN : dtt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dtt_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and memory port drive
    always_comb
    begin
        item_stall = (state_reg != dtt_pkg::ST_IDLE);
        res_valid  = (state_reg == dtt_pkg::ST_STATUS) || (state_reg == dtt_pkg::ST_FIRE);
        res        = res_reg;
        rd_en      = issuing;
        rd_addr    = ptr_reg[IDX_W-1:0];
        wr_en      = 1'b0;
        wr_addr    = free_idx;
        wr_data    = new_entry;
        case (state_reg)
            dtt_pkg::ST_IDLE:
            begin
                wr_en = accept && item.mode && (kind == dtt_pkg::EV_ACCEPTED);
            end
            dtt_pkg::ST_WALK:
            begin
                wr_en   = pv_reg && valid_reg[pidx_reg];
                wr_addr = pidx_reg;
                wr_data = walk_entry;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dtt_pkg::ST_IDLE;
            valid_reg      <= '0;
            fired_reg      <= '0;
            stamp_reg      <= '0;
            ptr_reg        <= '0;
            pv_reg         <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pv_reg    <= issuing;

            // Restart the pointer between passes
            if ((state_reg == dtt_pkg::ST_IDLE) || (state_reg == dtt_pkg::ST_FIRE)
                || pass_done)
            begin
                ptr_reg        <= '0;
                best_found_reg <= 1'b0;
            end
            else if (issuing)
            begin
                ptr_reg <= ptr_reg + CNT_W'(1);
            end

            // Claim a slot for an accepted request
            if (accept && item.mode && (kind == dtt_pkg::EV_ACCEPTED))
            begin
                valid_reg[free_idx] <= 1'b1;
                stamp_reg           <= stamp_reg + dtt_pkg::STAMP_W'(1);
            end

            // Mark entries that run out on this step
            if ((state_reg == dtt_pkg::ST_WALK) && pv_reg && valid_reg[pidx_reg]
                && (rd_entry.seconds <= dtt_pkg::SEC_W'(1)))
            begin
                fired_reg[pidx_reg] <= 1'b1;
            end

            // Track the newest fired entry
            if ((state_reg == dtt_pkg::ST_SCAN) && pv_reg && fired_reg[pidx_reg]
                && (!best_found_reg || (cand_d < best_d_reg)))
            begin
                best_found_reg <= 1'b1;
            end

            // Drop the chosen entry from the table
            if ((state_reg == dtt_pkg::ST_SCAN) && pass_done)
            begin
                valid_reg[best_idx_reg] <= 1'b0;
                fired_reg[best_idx_reg] <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pidx_reg <= ptr_reg[IDX_W-1:0];

        if ((state_reg == dtt_pkg::ST_SCAN) && pv_reg && fired_reg[pidx_reg]
            && (!best_found_reg || (cand_d < best_d_reg)))
        begin
            best_d_reg   <= cand_d;
            best_idx_reg <= pidx_reg;
            best_tag_reg <= rd_entry.tag;
        end

        if (accept && item.mode)
        begin
            res_reg.event_kind <= kind;
            res_reg.tag        <= (kind == dtt_pkg::EV_ACCEPTED) ? item.command_tag : '0;
            res_reg.last       <= 1'b1;
        end
        else if ((state_reg == dtt_pkg::ST_SCAN) && pass_done)
        begin
            res_reg.event_kind <= dtt_pkg::EV_FIRED;
            res_reg.tag        <= best_tag_reg;
            res_reg.last       <= (fired_left == '0);
        end
    end

    // Fired marks only ever sit on live entries
    a_fired_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (fired_reg & ~valid_reg) == '0)
        else $error("fired entry not in table");

    // A selection pass always finds an entry
    a_scan_finds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == dtt_pkg::ST_SCAN) && pass_done) |-> best_found_reg)
        else $error("scan pass ended without a fired entry");

    // The final fired word leaves nothing behind
    a_fire_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dtt_pkg::ST_FIRE) |-> (res_reg.last == (fired_reg == '0)))
        else $error("last flag disagrees with pending fired entries");

    // An accepted request adds exactly one live entry
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.mode && (kind == dtt_pkg::EV_ACCEPTED))
        |=> ($countones(valid_reg) == $past($countones(valid_reg)) + 1))
        else $error("insert did not add one entry");

endmodule

@@ rtl/delayed_action_timer_table_unit.sv @@
// ============================================================================
// delayed_action_timer_table_unit - countdown table for delayed actions
// Top level: prescaler, entry memory, controller and output register.
// ============================================================================
// A schedule word is taken while the controller is idle; its single status
// word is registered in the controller and then loaded into the output
// register once that register is empty or being drained. A tick word that
// causes no second step leaves the controller idle. A tick that does cause a
// second step walks the entry memory once and then, for each entry that
// fires, makes one selection scan of the memory and hands the word over;
// input words stall until this is done. Each pass reads the entries one by
// one through the single read port of the entry memory. Fired words leave
// newest entry first, the last one flagged. No clearing pass follows reset:
// slot occupancy lives in flip-flops.
// ============================================================================
module delayed_action_timer_table_unit #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  dtt_pkg::in_t              item,
    output logic                      result_valid,
    input  logic                      result_stall,
    output dtt_pkg::out_t             result,
    input  logic                      wr_en,
    input  logic [dtt_pkg::PPS_W-1:0] wr_data
);

    localparam int unsigned IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned ENTRY_W = $bits(dtt_pkg::entry_t);

    logic               tick;
    logic               step;
    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;
    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_rd_addr;
    logic [ENTRY_W-1:0] mem_rd_data;
    logic               res_valid;
    dtt_pkg::out_t      res;
    logic               load;
    logic               out_valid_reg;
    dtt_pkg::out_t      out_reg;

    assign tick = item_valid && !item_stall && !item.mode;

    dtt_prescaler u_prescaler (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .step    (step)
    );

    dtt_ram #(
        .DEPTH  (TABLE_DEPTH),
        .WIDTH  (ENTRY_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    dtt_ctrl #(
        .DEPTH   (TABLE_DEPTH),
        .IDX_W   (IDX_W),
        .ENTRY_W (ENTRY_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_stall (item_stall),
        .step       (step),
        .wr_en      (mem_wr_en),
        .wr_addr    (mem_wr_addr),
        .wr_data    (mem_wr_data),
        .rd_en      (mem_rd_en),
        .rd_addr    (mem_rd_addr),
        .rd_data    (mem_rd_data),
        .res_valid  (res_valid),
        .res        (res),
        .res_taken  (load)
    );

    // Load the output register when it is empty or being drained
    assign load = res_valid && (!out_valid_reg || !result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the result word while stalled
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb - self-checking bench for delayed_action_timer_table_unit
// Drives schedule and tick words into the timer table and predicts every
// status and fired word in a scoreboard. Each returned word is compared field
// by field. The bench runs a directed opening and then random phases under
// several prescaler settings and several patterns of stalls and gaps.
// ============================================================================
module tb;

    localparam int DEPTH  = 16;
    // Worst busy stretch of one tick: walk plus one scan per fired entry
    localparam int SETTLE = (DEPTH + 1) * (DEPTH + 2) + DEPTH + 16;
    localparam int STUCK_LIMIT = 20000;
    localparam int PHASE_ITEMS = 58;
    localparam bit [dtt_pkg::PPS_W-1:0] RATE_PLAN [6] =
        '{8'd255, 8'd0, 8'd2, 8'd1, 8'd7, 8'd1};

    // Prediction of the table; holds the words still owed by the block
    class countdown_scoreboard;
        bit                        live  [DEPTH];
        bit [dtt_pkg::SEC_W-1:0]   secs  [DEPTH];
        bit [dtt_pkg::TAG_W-1:0]   tags  [DEPTH];
        bit [dtt_pkg::STAMP_W-1:0] ages  [DEPTH];
        bit [dtt_pkg::STAMP_W-1:0] stamp;
        bit [dtt_pkg::PPS_W-1:0]   prescale;
        bit [dtt_pkg::PPS_W-1:0]   reload;
        dtt_pkg::out_t             due_words [$];
        int                        errors;

        function new();
            foreach (live[i])
            begin
                live[i] = 1'b0;
                secs[i] = '0;
                tags[i] = '0;
                ages[i] = '0;
            end
            stamp    = '0;
            prescale = '0;
            reload   = dtt_pkg::PPS_RESET;
            errors   = 0;
        endfunction

        function void set_reload(bit [dtt_pkg::PPS_W-1:0] v);
            reload = v;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        // Check a schedule word and book a slot when it passes every test
        function void schedule(dtt_pkg::in_t w);
            dtt_pkg::out_t        o;
            dtt_pkg::event_kind_t kind;
            int                   slot;
            slot = -1;
            o.tag = '0;
            if (!w.requester_permitted)
                kind = dtt_pkg::EV_NOT_PERMITTED;
            else if (!w.delay_present)
                kind = dtt_pkg::EV_NO_DELAY;
            else if (w.delay_seconds < dtt_pkg::DELAY_MIN
                     || w.delay_seconds > dtt_pkg::DELAY_MAX)
                kind = dtt_pkg::EV_OUT_OF_RANGE;
            else if (!w.command_present)
                kind = dtt_pkg::EV_NO_COMMAND;
            else
            begin
                for (int i = DEPTH - 1; i >= 0; i--)
                    if (!live[i])
                        slot = i;
                if (slot < 0)
                    kind = dtt_pkg::EV_TABLE_FULL;
                else
                begin
                    kind = dtt_pkg::EV_ACCEPTED;
                    live[slot] = 1'b1;
                    secs[slot] = w.delay_seconds[dtt_pkg::SEC_W-1:0];
                    tags[slot] = w.command_tag;
                    ages[slot] = stamp;
                    stamp++;
                    o.tag = w.command_tag;
                end
            end
            o.event_kind = kind;
            o.last = 1'b1;
            due_words.push_back(o);
        endfunction

        // Count every live entry down and release the expired ones, newest first
        function void second_step();
            bit                        hit [DEPTH];
            int                        total;
            int                        best;
            bit [dtt_pkg::STAMP_W-1:0] best_d;
            bit [dtt_pkg::STAMP_W-1:0] d;
            dtt_pkg::out_t             o;
            total = 0;
            for (int i = 0; i < DEPTH; i++)
            begin
                hit[i] = 1'b0;
                if (live[i])
                begin
                    if (secs[i] <= 1)
                    begin
                        secs[i] = '0;
                        hit[i] = 1'b1;
                        total++;
                    end
                    else
                        secs[i]--;
                end
            end
            for (int k = 0; k < total; k++)
            begin
                best = -1;
                best_d = '0;
                for (int i = 0; i < DEPTH; i++)
                begin
                    d = stamp - ages[i];
                    if (hit[i] && (best < 0 || d < best_d))
                    begin
                        best = i;
                        best_d = d;
                    end
                end
                hit[best] = 1'b0;
                live[best] = 1'b0;
                o.event_kind = dtt_pkg::EV_FIRED;
                o.tag = tags[best];
                o.last = (k == total - 1);
                due_words.push_back(o);
            end
        endfunction

        // Note an accepted input word and queue what it must cause
        function void take_item(dtt_pkg::in_t w);
            if (w.mode)
                schedule(w);
            else if (prescale <= 1)
            begin
                prescale = reload;
                second_step();
            end
            else
                prescale--;
        endfunction

        task report(string what, int got, int want);
            errors++;
            $display("%0t ns: %s got %0d want %0d", $time, what, got, want);
        endtask

        // Compare one returned word with the oldest owed one
        task check_word(dtt_pkg::out_t r);
            dtt_pkg::out_t want;
            if (due_words.size() == 0)
            begin
                report("unexpected result word, kind", int'(r.event_kind), -1);
                return;
            end
            want = due_words.pop_front();
            if (r.event_kind !== want.event_kind)
                report("event_kind", int'(r.event_kind), int'(want.event_kind));
            if (r.tag !== want.tag)
                report("tag", int'(r.tag), int'(want.tag));
            if (r.last !== want.last)
                report("last", int'(r.last), int'(want.last));
        endtask
    endclass

    logic                      clk;
    logic                      rst_n        = 1'b0;
    logic                      item_valid   = 1'b0;
    logic                      item_stall;
    dtt_pkg::in_t              item         = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    dtt_pkg::out_t             result;
    logic                      wr_en        = 1'b0;
    logic [dtt_pkg::PPS_W-1:0] wr_data      = '0;

    countdown_scoreboard sb;
    int unsigned send_idle_pct  = 34;
    int unsigned recv_stall_pct = 77;
    int          stuck_cycles   = 0;

    delayed_action_timer_table_unit #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .wr_en        (wr_en),
        .wr_data      (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stall the result side at random
    always @(negedge clk)
        result_stall <= ($urandom_range(99) < recv_stall_pct);

    // Check every result word taken
    always @(posedge clk)
        if (rst_n && result_valid && !result_stall)
            sb.check_word(result);

    // Abort when no word moves on either side for too long
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", STUCK_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one word, with random gaps before it, and hold it until taken
    task send_word(dtt_pkg::in_t w);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= w;
        do
            @(posedge clk);
        while (item_stall);
        sb.take_item(w);
    endtask

    task park();
        @(negedge clk);
        item_valid <= 1'b0;
    endtask

    task wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Let the block go quiet, then load a new prescaler reload
    task write_rate(bit [dtt_pkg::PPS_W-1:0] v);
        park();
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_data <= v;
        @(negedge clk);
        wr_en <= 1'b0;
        sb.set_reload(v);
    endtask

    function automatic dtt_pkg::in_t request(bit p, bit dp, bit [dtt_pkg::DELAY_W-1:0] d,
                                             bit cp, bit [dtt_pkg::TAG_W-1:0] t);
        dtt_pkg::in_t w;
        w.mode = 1'b1;
        w.requester_permitted = p;
        w.delay_present = dp;
        w.delay_seconds = d;
        w.command_present = cp;
        w.command_tag = t;
        return w;
    endfunction

    // Tick word; the other fields carry noise the block must ignore
    function automatic dtt_pkg::in_t random_tick();
        dtt_pkg::in_t w;
        logic [63:0]  r;
        r = {$urandom, $urandom};
        w = r[$bits(dtt_pkg::in_t)-1:0];
        w.mode = 1'b0;
        return w;
    endfunction

    // Mostly well-formed requests with short delays, the rest broken or noisy
    function automatic dtt_pkg::in_t random_request();
        dtt_pkg::in_t                w;
        int unsigned                 pick;
        bit [dtt_pkg::DELAY_W-1:0]   d;
        pick = $urandom_range(99);
        if (pick < 72)
            d = dtt_pkg::DELAY_W'($urandom_range(5, 10));
        else if (pick < 79)
            d = dtt_pkg::DELAY_W'($urandom_range(11, 60));
        else if (pick < 80)
            d = dtt_pkg::DELAY_MAX;
        else
            case ($urandom_range(3))
                0: d = dtt_pkg::DELAY_W'($urandom);
                1: d = dtt_pkg::DELAY_MIN - 16'd1;
                2: d = dtt_pkg::DELAY_MAX + 16'd1;
                default: d = dtt_pkg::DELAY_W'($urandom_range(5, 10));
            endcase
        if (pick < 80)
            w = request(1'b1, 1'b1, d, 1'b1, dtt_pkg::TAG_W'($urandom));
        else
            w = request(1'($urandom), 1'($urandom), d, 1'($urandom),
                        dtt_pkg::TAG_W'($urandom));
        return w;
    endfunction

    task run_phase(int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            // now and then hold off until the table has answered everything
            if ($urandom_range(29) == 0)
            begin
                park();
                wait_drained();
            end
            if ($urandom_range(99) < 45)
                send_word(random_tick());
            else
                send_word(random_request());
        end
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset reload: the first tick steps at once, then every fourth
        send_word(random_tick());
        send_word(request(1'b0, 1'b1, 16'd10, 1'b1, 16'h0101));
        send_word(request(1'b1, 1'b0, 16'd10, 1'b1, 16'h0202));
        send_word(request(1'b1, 1'b1, dtt_pkg::DELAY_MIN - 16'd1, 1'b1, 16'h0303));
        send_word(request(1'b1, 1'b1, dtt_pkg::DELAY_MAX + 16'd1, 1'b1, 16'h0404));
        send_word(request(1'b1, 1'b1, 16'd0, 1'b1, 16'h0505));
        send_word(request(1'b1, 1'b1, 16'hFFFF, 1'b1, 16'h0606));
        send_word(request(1'b1, 1'b1, 16'd5, 1'b0, 16'h0707));
        repeat (4) send_word(random_tick());

        // Two entries expire together and leave newest first, then a later one
        write_rate(8'd1);
        send_word(request(1'b1, 1'b1, dtt_pkg::DELAY_MIN, 1'b1, 16'hFFFF));
        send_word(request(1'b1, 1'b1, dtt_pkg::DELAY_MAX, 1'b1, 16'h0000));
        send_word(request(1'b1, 1'b1, dtt_pkg::DELAY_MIN, 1'b1, 16'h1234));
        send_word(request(1'b1, 1'b1, 16'd6, 1'b1, 16'hA5A5));
        repeat (9) send_word(random_tick());

        // Random phases: gaps on both sides, then swapped, then none
        for (int p = 0; p < 6; p++)
        begin
            write_rate(RATE_PLAN[p]);
            case (p / 2)
                0:
                begin
                    send_idle_pct  = 34;
                    recv_stall_pct = 77;
                end
                1:
                begin
                    send_idle_pct  = 77;
                    recv_stall_pct = 34;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            run_phase(PHASE_ITEMS);
        end

        park();
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/dtt_pkg.sv
rtl/dtt_ram.sv
rtl/dtt_prescaler.sv
rtl/dtt_ctrl.sv
rtl/delayed_action_timer_table_unit.sv
test/tb.sv
